// ----- src/gprc_pkg.sv -----
// Package for the grid pair rectangle counter: sizes, request and result
// types, command codes and small helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gprc_pkg;

    // Grid capacity.
    localparam int MAX_ROWS  = 512;
    localparam int MAX_COLS  = 512;

    // Fixed field widths.
    localparam int FIELD_W   = 10;
    localparam int COUNT_W   = 20;
    localparam int EDGE_W    = 10;

    // Derived widths.
    localparam int ROW_W     = $clog2(MAX_ROWS + 2);
    localparam int COL_W     = $clog2(MAX_COLS + 2);
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_IDX_W = $clog2(MAX_COLS);
    localparam int CMP_W     = 14;

    // Configuration port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Command queue.
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // Register indexes, taken from paddr[2].
    typedef enum logic {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } reg_idx_t;

    // Request actions.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic               action;
        logic               cell_open;
        logic [FIELD_W-1:0] top_row;
        logic [FIELD_W-1:0] left_col;
        logic [FIELD_W-1:0] bottom_row;
        logic [FIELD_W-1:0] right_col;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pair_count;
        logic               bad_query;
    } rsp_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_BAD
    } cmd_kind_t;

    // One classified command between the front and back ends.
    typedef struct packed {
        cmd_kind_t        kind;
        logic [ROW_W-1:0] r1;
        logic [COL_W-1:0] c1;
        logic [ROW_W-1:0] r2;
        logic [COL_W-1:0] c2;
        logic             up;
        logic             left;
    } cmd_t;

    // A dimension register of zero acts as one; large values saturate.
    function automatic logic [CMP_W-1:0] clamp_dim(input logic [FIELD_W-1:0] v,
                                                   input logic [CMP_W-1:0] maxv);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0)
            return CMP_W'(1);
        else if (ext > maxv)
            return maxv;
        else
            return ext;
    endfunction

    // Flat address of a 1-based cell.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CMP_W-1:0] r,
                                                    input logic [CMP_W-1:0] c);
        logic [31:0] full;
        full = (32'(r) - 32'd1) * 32'(MAX_COLS) + (32'(c) - 32'd1);
        return full[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/gprc_front.sv -----
// Front end: accepts requests, tracks the load position and the row above,
// and classifies each request into a command. Depends on gprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gprc_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire gprc_pkg::req_t            req_data,
    input  wire logic [gprc_pkg::CMP_W-1:0] grid_rows,
    input  wire logic [gprc_pkg::CMP_W-1:0] grid_cols,
    input  wire logic                      q_full,
    output logic                           push_valid,
    output gprc_pkg::cmd_t                 push_cmd
);
    import gprc_pkg::*;

    logic [ROW_W-1:0]     load_row_reg, load_row_next;
    logic [COL_W-1:0]     load_col_reg, load_col_next;
    logic [COL_W-1:0]     fill_reg, fill_next;
    logic                 left_open_reg, left_open_next;
    logic                 prior_rd_reg;
    logic                 prior_mem [MAX_COLS];
    logic                 accept, do_load, is_query, wrap, prior_ok, bad;
    logic [CMP_W-1:0]     row_ext, col_ext, r1, c1, r2, c2;
    logic [COL_IDX_W-1:0] widx, ridx;

    assign req_ready = !q_full;
    assign accept    = req_valid && !q_full;

    // Classify the request and advance the load position.
    always_comb
    begin
        row_ext  = CMP_W'(load_row_reg);
        col_ext  = CMP_W'(load_col_reg);
        do_load  = accept && (req_data.action == ACT_LOAD) && (row_ext <= grid_rows);
        is_query = accept && (req_data.action == ACT_QUERY);
        wrap     = col_ext >= grid_cols;
        prior_ok = col_ext <= CMP_W'(fill_reg);

        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        left_open_next = left_open_reg;
        fill_next      = fill_reg;
        if (do_load)
        begin
            if (wrap)
            begin
                load_col_next  = COL_W'(1);
                load_row_next  = load_row_reg + ROW_W'(1);
                left_open_next = 1'b0;
            end
            else
            begin
                load_col_next  = load_col_reg + COL_W'(1);
                left_open_next = req_data.cell_open;
            end
            if (load_col_reg > fill_reg)
                fill_next = load_col_reg;
        end

        r1  = CMP_W'(req_data.top_row);
        c1  = CMP_W'(req_data.left_col);
        r2  = CMP_W'(req_data.bottom_row);
        c2  = CMP_W'(req_data.right_col);
        bad = (r1 == '0) || (c1 == '0) || (r1 > r2) || (c1 > c2) ||
              (r2 > grid_rows) || (c2 > grid_cols);

        push_valid = do_load || is_query;
        push_cmd.up   = req_data.cell_open && prior_ok && prior_rd_reg;
        push_cmd.left = req_data.cell_open && left_open_reg;
        if (req_data.action == ACT_LOAD)
        begin
            push_cmd.kind = CMD_LOAD;
            push_cmd.r1   = load_row_reg;
            push_cmd.c1   = load_col_reg;
        end
        else
        begin
            push_cmd.kind = bad ? CMD_BAD : CMD_QUERY;
            push_cmd.r1   = ROW_W'(req_data.top_row);
            push_cmd.c1   = COL_W'(req_data.left_col);
        end
        push_cmd.r2 = ROW_W'(req_data.bottom_row);
        push_cmd.c2 = COL_W'(req_data.right_col);

        widx = COL_IDX_W'(load_col_reg - COL_W'(1));
        ridx = COL_IDX_W'(load_col_next - COL_W'(1));
    end

    // Load position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg  <= ROW_W'(1);
            load_col_reg  <= COL_W'(1);
            left_open_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            left_open_reg <= left_open_next;
            fill_reg      <= fill_next;
        end
    end

    // Row-above memory; the read tracks the next load column and forwards a
    // same-column write. Columns past the fill mark read as blocked.
    always_ff @(posedge clk)
    begin
        if (do_load)
            prior_mem[widx] <= req_data.cell_open;
        if (do_load && (widx == ridx))
            prior_rd_reg <= req_data.cell_open;
        else
            prior_rd_reg <= prior_mem[ridx];
    end

endmodule

`default_nettype wire

// ----- src/gprc_queue.sv -----
// Short command queue between the front and back ends.
// Depends on gprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gprc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    input  wire gprc_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output gprc_pkg::cmd_t      head
);
    import gprc_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full    = count_reg == QCNT_W'(QDEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- src/gprc_back.sv -----
// Back end: holds the summed-area and edge-prefix memories, writes one cell
// per load and answers queries from two rounds of reads. Depends on gprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gprc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    input  wire gprc_pkg::cmd_t head,
    output logic                pop,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output gprc_pkg::rsp_t      rsp_data
);
    import gprc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_QRY_B,
        ST_QRY_C
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg, cur;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic                out_free;
    logic                rsp_set;

    logic [COUNT_W-1:0]  pair_mem  [CELLS];
    logic [EDGE_W-1:0]   horiz_mem [CELLS];
    logic [EDGE_W-1:0]   vert_mem  [CELLS];
    logic [COUNT_W-1:0]  pair_rd0_reg, pair_rd1_reg;
    logic [EDGE_W-1:0]   horiz_rd0_reg, horiz_rd1_reg, vert_rd0_reg, vert_rd1_reg;
    logic [ADDR_W-1:0]   pair_ra0, pair_ra1, horiz_ra0, horiz_ra1, vert_ra0, vert_ra1;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CMP_W-1:0]    r1, c1, r2, c2;

    logic [COUNT_W-1:0]  last_p_reg, diag_reg, part_reg;
    logic [EDGE_W-1:0]   last_v_reg, lefts_reg, ups_reg;
    logic                top_row_cell, first_col_cell;
    logic [COUNT_W-1:0]  pu, lp, dg, new_p, b_val, c_val, d_val, total;
    logic [EDGE_W-1:0]   hu, lv, new_h, new_v, h1_val, v1_val;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Read addresses: the queue head in idle, the held command otherwise.
    always_comb
    begin
        cur = (state_reg == ST_IDLE) ? head : cmd_reg;
        r1  = CMP_W'(cur.r1);
        c1  = CMP_W'(cur.c1);
        r2  = CMP_W'(cur.r2);
        c2  = CMP_W'(cur.c2);
        if (state_reg == ST_IDLE)
        begin
            if (cur.kind == CMD_LOAD)
                pair_ra0 = cell_addr(r1 - CMP_W'(1), c1);
            else
                pair_ra0 = cell_addr(r2, c2);
            pair_ra1 = cell_addr(r2, c1 - CMP_W'(1));
        end
        else
        begin
            pair_ra0 = cell_addr(r1 - CMP_W'(1), c2);
            pair_ra1 = cell_addr(r1 - CMP_W'(1), c1 - CMP_W'(1));
        end
        horiz_ra0 = (cur.kind == CMD_LOAD) ? cell_addr(r1 - CMP_W'(1), c1)
                                           : cell_addr(r2, c1);
        horiz_ra1 = cell_addr(r1 - CMP_W'(1), c1);
        vert_ra0  = cell_addr(r1, c2);
        vert_ra1  = cell_addr(r1, c1 - CMP_W'(1));
        wr_addr   = cell_addr(CMP_W'(cmd_reg.r1), CMP_W'(cmd_reg.c1));
    end

    // Load arithmetic; row one and column one see zero neighbors.
    always_comb
    begin
        top_row_cell   = cmd_reg.r1 == ROW_W'(1);
        first_col_cell = cmd_reg.c1 == COL_W'(1);
        pu    = top_row_cell ? '0 : pair_rd0_reg;
        hu    = top_row_cell ? '0 : horiz_rd0_reg;
        lp    = first_col_cell ? '0 : last_p_reg;
        lv    = first_col_cell ? '0 : last_v_reg;
        dg    = (top_row_cell || first_col_cell) ? '0 : diag_reg;
        new_p = pu + lp - dg + COUNT_W'(cmd_reg.up) + COUNT_W'(cmd_reg.left);
        new_h = hu + EDGE_W'(cmd_reg.left);
        new_v = lv + EDGE_W'(cmd_reg.up);
    end

    // Query arithmetic; reads at row zero or column zero count as zero.
    always_comb
    begin
        b_val  = first_col_cell ? '0 : pair_rd1_reg;
        h1_val = top_row_cell ? '0 : horiz_rd1_reg;
        v1_val = first_col_cell ? '0 : vert_rd1_reg;
        c_val  = top_row_cell ? '0 : pair_rd0_reg;
        d_val  = (top_row_cell || first_col_cell) ? '0 : pair_rd1_reg;
        total  = part_reg - c_val + d_val - COUNT_W'(lefts_reg) - COUNT_W'(ups_reg);
    end

    assign pop = (state_reg == ST_IDLE) && !empty && ((head.kind != CMD_BAD) || out_free);

    // A new result is loaded into the output register in this cycle.
    assign rsp_set = ((state_reg == ST_IDLE) && pop && (head.kind == CMD_BAD)) ||
                     ((state_reg == ST_QRY_C) && out_free);

    // Memories: one write and two registered reads per cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD_WR)
        begin
            pair_mem[wr_addr]  <= new_p;
            horiz_mem[wr_addr] <= new_h;
            vert_mem[wr_addr]  <= new_v;
        end
        pair_rd0_reg  <= pair_mem[pair_ra0];
        pair_rd1_reg  <= pair_mem[pair_ra1];
        horiz_rd0_reg <= horiz_mem[horiz_ra0];
        horiz_rd1_reg <= horiz_mem[horiz_ra1];
        vert_rd0_reg  <= vert_mem[vert_ra0];
        vert_rd1_reg  <= vert_mem[vert_ra1];
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            cmd_reg       <= '0;
            last_p_reg    <= '0;
            last_v_reg    <= '0;
            diag_reg      <= '0;
            part_reg      <= '0;
            lefts_reg     <= '0;
            ups_reg       <= '0;
        end
        else
        begin
            if (rsp_set)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cmd_reg <= head;
                        unique case (head.kind)
                            CMD_LOAD:  state_reg <= ST_LOAD_WR;
                            CMD_QUERY: state_reg <= ST_QRY_B;
                            default:
                            begin
                                rsp_reg.pair_count <= '0;
                                rsp_reg.bad_query  <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_LOAD_WR:
                begin
                    last_p_reg <= new_p;
                    last_v_reg <= new_v;
                    diag_reg   <= pu;
                    state_reg  <= ST_IDLE;
                end
                ST_QRY_B:
                begin
                    part_reg  <= pair_rd0_reg - b_val;
                    lefts_reg <= horiz_rd0_reg - h1_val;
                    ups_reg   <= vert_rd0_reg - v1_val;
                    state_reg <= ST_QRY_C;
                end
                ST_QRY_C:
                begin
                    if (out_free)
                    begin
                        rsp_reg.pair_count <= total;
                        rsp_reg.bad_query  <= 1'b0;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/grid_pair_rect_counter.sv -----
// Grid pair rectangle counter, top level: configuration registers and the
// front end, command queue and back end. Depends on gprc_pkg and gprc_*.
//
// Counts adjacent open cell pairs inside a query rectangle of a binary grid.
// Load requests bring cells in row-major order and give no result; query
// requests give one result each. The front end takes a request in the cycle
// it arrives whenever the two-entry command queue has room. In the back end
// a load makes a registered read of the row above, then writes the
// summed-area, column and row prefix memories; a query makes two rounds
// of two reads on each memory's read ports, then the final sum; and a query
// with bad corners is answered from the idle state. A result waits in
// an output register while the next request is taken. The memories need no
// clearing after reset; querying cells not yet loaded gives undefined counts.
`timescale 1ns / 1ps
`default_nettype none

module grid_pair_rect_counter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire gprc_pkg::req_t                req_data,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output gprc_pkg::rsp_t                     rsp_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gprc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [gprc_pkg::PDATA_W-1:0]  pwdata,
    output logic [gprc_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import gprc_pkg::*;

    logic [FIELD_W-1:0] grid_rows_reg, grid_cols_reg;
    logic [CMP_W-1:0]   grid_rows_eff, grid_cols_eff;
    reg_idx_t           reg_sel;
    logic               q_full, q_empty, push_valid, pop;
    cmd_t               push_cmd, head;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= FIELD_W'(512);
            grid_cols_reg <= FIELD_W'(512);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_GRID_ROWS: grid_rows_reg <= pwdata[FIELD_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= pwdata[FIELD_W-1:0];
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (reg_sel)
            REG_GRID_ROWS: prdata = PDATA_W'(grid_rows_reg);
            REG_GRID_COLS: prdata = PDATA_W'(grid_cols_reg);
            default:       prdata = '0;
        endcase
    end

    assign grid_rows_eff = clamp_dim(grid_rows_reg, CMP_W'(MAX_ROWS));
    assign grid_cols_eff = clamp_dim(grid_cols_reg, CMP_W'(MAX_COLS));

    gprc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .grid_rows  (grid_rows_eff),
        .grid_cols  (grid_cols_eff),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    gprc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    gprc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

// ----- src/gprc_checker.sv -----
// Port-level checks for the grid pair rectangle counter, bound to the top
// level. Depends on gprc_pkg and grid_pair_rect_counter.
`timescale 1ns / 1ps
`default_nettype none

module gprc_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rsp_valid,
    input  wire logic                         rsp_ready,
    input  wire gprc_pkg::rsp_t               rsp_data,
    input  wire logic [gprc_pkg::PDATA_W-1:0] prdata,
    input  wire logic                         pready
);
    import gprc_pkg::*;

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // A bad query always reports a zero count.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.bad_query |-> rsp_data.pair_count == '0)
        else $error("bad query with nonzero count");

    // Register reads carry only the register field.
    a_prdata: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[PDATA_W-1:FIELD_W] == '0)
        else $error("register read has stray upper bits");

    // The configuration port never waits.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind grid_pair_rect_counter gprc_checker u_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for grid_pair_rect_counter: directed and random load and query
// requests, checked against a summed-area predictor. Depends on gprc_pkg.
`timescale 1ns / 1ps

module tb;
    import gprc_pkg::*;

    // Predicts query results from the loaded grid and checks each response.
    class pair_count_board;
        bit [19:0] pair_sum [int];
        bit [9:0]  horiz_run [int];
        bit [9:0]  vert_run [int];
        bit        above_open [int];
        int        row_ptr;
        int        col_ptr;
        bit        left_open;
        bit [9:0]  rows_reg;
        bit [9:0]  cols_reg;
        rsp_t      expected_rsp [$];
        int        errors;
        int        queries;
        int        loads;

        function new();
            row_ptr = 1;
            col_ptr = 1;
            left_open = 0;
            rows_reg = 10'd512;
            cols_reg = 10'd512;
            errors = 0;
            queries = 0;
            loads = 0;
        endfunction

        function int eff_dim(bit [9:0] v, int maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return int'(v);
        endfunction

        function int key(int r, int c);
            return (r - 1) * MAX_COLS + (c - 1);
        endfunction

        function bit [31:0] rd_pair(int r, int c);
            if (r == 0 || c == 0 || !pair_sum.exists(key(r, c)))
                return 0;
            return 32'(pair_sum[key(r, c)]);
        endfunction

        function bit [31:0] rd_horiz(int r, int c);
            if (r == 0 || c == 0 || !horiz_run.exists(key(r, c)))
                return 0;
            return 32'(horiz_run[key(r, c)]);
        endfunction

        function bit [31:0] rd_vert(int r, int c);
            if (r == 0 || c == 0 || !vert_run.exists(key(r, c)))
                return 0;
            return 32'(vert_run[key(r, c)]);
        endfunction

        // True when the entry was written or lies on the zero border.
        function bit known(int r, int c);
            return r == 0 || c == 0 || pair_sum.exists(key(r, c));
        endfunction

        // A good query may only read entries of loaded cells.
        function bit query_ok(req_t q);
            int r1;
            int c1;
            int r2;
            int c2;
            r1 = q.top_row;
            c1 = q.left_col;
            r2 = q.bottom_row;
            c2 = q.right_col;
            if (is_bad(q))
                return 1;
            return known(r2, c2) && known(r2, c1 - 1) && known(r1 - 1, c2)
                && known(r1 - 1, c1 - 1) && known(r2, c1) && known(r1 - 1, c1)
                && known(r1, c2) && known(r1, c1 - 1);
        endfunction

        function bit is_bad(req_t q);
            return q.top_row < 1 || q.left_col < 1 || q.top_row > q.bottom_row
                || q.left_col > q.right_col
                || q.bottom_row > eff_dim(rows_reg, MAX_ROWS)
                || q.right_col > eff_dim(cols_reg, MAX_COLS);
        endfunction

        function void note_request(req_t q);
            int r;
            int c;
            bit up;
            bit lt;
            bit [31:0] total;
            bit [31:0] lefts;
            bit [31:0] ups;
            rsp_t rsp;
            r = row_ptr;
            c = col_ptr;
            if (q.action == ACT_LOAD) begin
                loads++;
                if (r > eff_dim(rows_reg, MAX_ROWS))
                    return;
                up = q.cell_open & (above_open.exists(c) ? above_open[c] : 1'b0);
                lt = q.cell_open & left_open;
                // A cell built on neighbors that were never loaded stays
                // unknown, and so do cells built on it.
                if (known(r - 1, c) && known(r - 1, c - 1) && known(r, c - 1)) begin
                    pair_sum[key(r, c)] = 20'(rd_pair(r - 1, c) + rd_pair(r, c - 1)
                                        - rd_pair(r - 1, c - 1) + up + lt);
                    horiz_run[key(r, c)] = 10'(rd_horiz(r - 1, c) + lt);
                    vert_run[key(r, c)] = 10'(rd_vert(r, c - 1) + up);
                end
                above_open[c] = q.cell_open;
                left_open = q.cell_open;
                if (c >= eff_dim(cols_reg, MAX_COLS)) begin
                    col_ptr = 1;
                    row_ptr = r + 1;
                    left_open = 0;
                end
                else
                    col_ptr = c + 1;
                return;
            end
            queries++;
            if (is_bad(q)) begin
                rsp.pair_count = '0;
                rsp.bad_query = 1'b1;
            end
            else begin
                total = rd_pair(q.bottom_row, q.right_col)
                      - rd_pair(q.bottom_row, q.left_col - 1)
                      - rd_pair(q.top_row - 1, q.right_col)
                      + rd_pair(q.top_row - 1, q.left_col - 1);
                lefts = (rd_horiz(q.bottom_row, q.left_col)
                      - rd_horiz(q.top_row - 1, q.left_col)) & 32'h3FF;
                ups = (rd_vert(q.top_row, q.right_col)
                    - rd_vert(q.top_row, q.left_col - 1)) & 32'h3FF;
                total = total - lefts - ups;
                rsp.pair_count = total[19:0];
                rsp.bad_query = 1'b0;
            end
            expected_rsp.push_back(rsp);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0) begin
                report("response with no query pending", 0, 0);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.pair_count !== want.pair_count)
                report("pair_count", int'(got.pair_count), int'(want.pair_count));
            if (got.bad_query !== want.bad_query)
                report("bad_query", int'(got.bad_query), int'(want.bad_query));
        endfunction

        function void report(string what, int got, int want);
            errors++;
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req_data;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    pair_count_board board;
    int cycles;
    int burst_left;

    grid_pair_rect_counter dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000) begin
            $display("grid_pair_rect_counter regression: fail");
            $finish;
        end
    end

    // Response side: stalls on its own pattern, with stall-free stretches.
    always @(negedge clk)
    begin
        if ((cycles / 300) % 3 == 0)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ((cycles % 16) < 10) && ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_response(rsp_data);
    end

    // Writes a register, then reads it back.
    task automatic write_reg(reg_idx_t idx, logic [9:0] value);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1;
        paddr = PADDR_W'(idx) << 2;
        pwdata = 32'(value);
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        if (idx == REG_GRID_ROWS)
            board.rows_reg = value;
        else
            board.cols_reg = value;
        @(negedge clk);
        penable = 0; pwrite = 0;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        if (prdata[9:0] !== value)
            board.report("register readback", int'(prdata[9:0]), int'(value));
        @(negedge clk);
        psel = 0; penable = 0;
    endtask

    // Sends one request; valid stays high into the next request of a burst.
    task automatic send_request(req_t q);
        req_data = q;
        req_valid = 1;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_request(q);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else begin
            req_valid = 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic load_cell(bit open);
        req_t q;
        q = '0;
        q.action = ACT_LOAD;
        q.cell_open = open;
        q.top_row = 10'($urandom);
        q.left_col = 10'($urandom);
        q.bottom_row = 10'($urandom);
        q.right_col = 10'($urandom);
        send_request(q);
    endtask

    task automatic query(int r1, int c1, int r2, int c2);
        req_t q;
        q.action = ACT_QUERY;
        q.cell_open = 1'($urandom);
        q.top_row = 10'(r1);
        q.left_col = 10'(c1);
        q.bottom_row = 10'(r2);
        q.right_col = 10'(c2);
        send_request(q);
    endtask

    // Waits out every pending result and the loads still in flight.
    task automatic drain();
        req_valid = 0;
        while (board.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        req_t q;
        int gr;
        int gc;
        int tries;
        int hi;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 55) begin
                load_cell($urandom_range(0, 99) < 65);
                continue;
            end
            gr = board.eff_dim(board.rows_reg, MAX_ROWS);
            gc = board.eff_dim(board.cols_reg, MAX_COLS);
            q.action = ACT_QUERY;
            q.cell_open = 1'($urandom);
            if ($urandom_range(0, 99) < 20) begin
                // Noise corners, mostly out of range or reversed.
                q.top_row = 10'($urandom);
                q.left_col = 10'($urandom);
                q.bottom_row = 10'($urandom);
                q.right_col = 10'($urandom);
            end
            else begin
                tries = 0;
                do begin
                    hi = (board.row_ptr < gr) ? board.row_ptr : gr;
                    q.bottom_row = 10'($urandom_range(1, hi));
                    q.top_row = 10'($urandom_range(1, q.bottom_row));
                    q.right_col = 10'($urandom_range(1, gc));
                    q.left_col = 10'($urandom_range(1, q.right_col));
                    tries++;
                end while (!board.query_ok(q) && tries < 40);
            end
            if (!board.query_ok(q))
                q.top_row = '0;
            send_request(q);
        end
    endtask

    initial
    begin
        int rows_set [6] = '{1023, 1023, 512, 512, 0, 600};
        int cols_set [6] = '{0, 7, 13, 1023, 3, 5};
        int count_set [6] = '{40, 150, 150, 60, 40, 80};
        board = new();
        cycles = 0;
        burst_left = 0;
        rst_n = 0;
        req_valid = 0;
        req_data = '0;
        rsp_ready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (11) @(negedge clk);
        rst_n = 1;

        // Directed: part of row one, then good and bad corners.
        write_reg(REG_GRID_ROWS, 10'd512);
        write_reg(REG_GRID_COLS, 10'd512);
        load_cell(1); load_cell(1); load_cell(0);
        load_cell(1); load_cell(1); load_cell(1);
        query(1, 1, 1, 6);
        query(1, 3, 1, 3);
        query(1, 4, 1, 5);
        query(0, 1, 1, 1);
        query(1, 0, 1, 1);
        query(2, 1, 1, 1);
        query(1, 3, 1, 2);
        query(513, 1, 513, 1);
        query(1, 1, 1, 1023);
        query(1023, 1023, 1023, 1023);
        query(1, 1, 1, 1);
        drain();

        // Settings change mid-row, so the load position wraps early.
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_GRID_ROWS, 10'(rows_set[p]));
            write_reg(REG_GRID_COLS, 10'(cols_set[p]));
            random_phase(count_set[p]);
            drain();
        end

        $display("covered %0d loads and %0d queries over six grid settings",
                 board.loads, board.queries);
        if (board.errors == 0)
            $display("grid_pair_rect_counter regression: pass");
        else
            $display("grid_pair_rect_counter regression: fail");
        $finish;
    end
endmodule
